### src/assert_macros.svh
// Shared assertion macros for the frame parser checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define CFP_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("cfp: same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define CFP_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("cfp: next-cycle check failed");

`endif

### src/cfp_pkg.sv
package cfp_pkg;

	localparam int MAX_FRAME_BYTES = 128;
	localparam int LIMIT_CAP       = 1024;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 16;
	localparam int POS_W  = 11;
	localparam int CFG_W  = 11;
	localparam int IDX_W  = 1;

	localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd165;
	localparam logic [POS_W-1:0]  MAX_LEN_RST    = POS_W'(MAX_FRAME_BYTES - 7);
	localparam logic [POS_W-1:0]  LIMIT_MAX      = POS_W'(LIMIT_CAP);

	localparam logic [7:0]  HCRC_INIT  = 8'hFF;
	localparam logic [15:0] FCRC_INIT  = 16'hFFFF;
	localparam logic [7:0]  CRC8_POLY  = 8'h8C;
	localparam logic [15:0] CRC16_POLY = 16'h8408;

	localparam logic [IDX_W-1:0] REG_START_BYTE   = 1'b0;
	localparam logic [IDX_W-1:0] REG_MAX_DATA_LEN = 1'b1;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_SEQ,
		PH_HCRC,
		PH_BODY,
		PH_TRL_LO,
		PH_TRL_HI
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_GOOD,
		KIND_BAD,
		KIND_REJECT
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] value;
		logic [POS_W-1:0]  position;
		logic [LEN_W-1:0]  payload_length;
		logic [BYTE_W-1:0] sequence_res;
	} res_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### src/cfp_out_skid.sv
module cfp_out_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cfp_pkg::res_t push_res,
	output logic          space,
	output logic          out_valid,
	input  logic          out_ready,
	output cfp_pkg::res_t out_res
);
	import cfp_pkg::*;

	logic out_valid_q;
	logic skd_valid_q;
	res_t out_res_q;
	res_t skd_res_q;
	logic slot_free;

	assign slot_free = out_ready || !out_valid_q;
	assign space     = !skd_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skd_valid_q <= 1'b0;
		end else if (slot_free) begin
			if (skd_valid_q) begin
				out_valid_q <= 1'b1;
				skd_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			out_res_q <= skd_valid_q ? skd_res_q : push_res;
		end else if (push) begin
			skd_res_q <= push_res;
		end
	end

endmodule

### src/crc_checked_frame_parser_core.sv
// Serial frame parser with header CRC-8 and frame CRC-16 checking.
// Input channel: in_valid/in_ready with data_byte, one received byte per transfer.
// Output channel: out_valid/out_ready with kind, value, position, payload_length
// and sequence_res; a byte gives at most one result.
// Command and payload bytes come out as kind 0 with their offset; the frame ends
// with a good or bad verdict, and a long length or a header CRC-8 mismatch gives
// a header reject before the hunt for the start byte restarts.
// Throughput: one byte per cycle while in_ready is high; the bitwise CRC-8 and
// CRC-16 steps and the phase update lie between the parser state and the result
// register, and a result enters the output stage when its byte is transferred.
// A two-entry output stage (result register plus skid register) keeps in_ready
// high while one result waits; in_ready drops only when both entries are full,
// so a stalled receiver holds the parser after at most one further result.
// cfg_wr_en writes start_byte (index 0) or max_data_len (index 1) from cfg_wdata;
// write only while idle. Reset clears the parser to hunting, start_byte to 165
// and max_data_len to 121, and empties the output stage.
module crc_checked_frame_parser_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [cfp_pkg::IDX_W-1:0]   cfg_index,
	input  logic [cfp_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [cfp_pkg::BYTE_W-1:0]  data_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output cfp_pkg::kind_t              kind,
	output logic [cfp_pkg::BYTE_W-1:0]  value,
	output logic [cfp_pkg::POS_W-1:0]   position,
	output logic [cfp_pkg::LEN_W-1:0]   payload_length,
	output logic [cfp_pkg::BYTE_W-1:0]  sequence_res
);
	import cfp_pkg::*;

	phase_t            phase_q, phase_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [BYTE_W-1:0] seq_q, seq_d;
	logic [POS_W-1:0]  count_q, count_d;
	logic [7:0]        hcrc_q, hcrc_d;
	logic [15:0]       fcrc_q, fcrc_d;
	logic [BYTE_W-1:0] trl_q, trl_d;
	logic [BYTE_W-1:0] start_q;
	logic [POS_W-1:0]  max_len_q;

	logic              accept;
	logic              res_valid;
	res_t              res;
	res_t              out_res;
	logic [POS_W-1:0]  limit;
	logic [LEN_W-1:0]  len_full;
	logic [7:0]        hcrc_step;
	logic [15:0]       fcrc_step;
	logic [POS_W-1:0]  count_inc;

	assign accept    = in_valid && in_ready;
	assign limit     = (max_len_q > LIMIT_MAX) ? LIMIT_MAX : max_len_q;
	assign len_full  = {data_byte, len_q[7:0]};
	assign hcrc_step = crc8_step(hcrc_q, data_byte);
	assign fcrc_step = crc16_step(fcrc_q, data_byte);
	assign count_inc = count_q + 11'd1;

	always_comb begin
		phase_d   = phase_q;
		len_d     = len_q;
		seq_d     = seq_q;
		count_d   = count_q;
		hcrc_d    = hcrc_q;
		fcrc_d    = fcrc_q;
		trl_d     = trl_q;
		res_valid = 1'b0;
		res       = '{kind: KIND_BYTE, value: '0, position: '0,
		              payload_length: len_q, sequence_res: seq_q};
		case (phase_q)
			PH_HUNT: begin
				if (data_byte == start_q) begin
					phase_d = PH_LEN_LO;
					count_d = '0;
					trl_d   = '0;
					hcrc_d  = crc8_step(HCRC_INIT, data_byte);
					fcrc_d  = crc16_step(FCRC_INIT, data_byte);
				end
			end
			PH_LEN_LO: begin
				len_d   = {8'h00, data_byte};
				seq_d   = '0;
				hcrc_d  = hcrc_step;
				fcrc_d  = fcrc_step;
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_d = len_full;
				if (len_full >= {5'b00000, limit}) begin
					res_valid = 1'b1;
					res       = '{kind: KIND_REJECT, value: '0, position: '0,
					              payload_length: len_full, sequence_res: '0};
					phase_d   = PH_HUNT;
					hcrc_d    = HCRC_INIT;
					fcrc_d    = FCRC_INIT;
				end else begin
					hcrc_d  = hcrc_step;
					fcrc_d  = fcrc_step;
					phase_d = PH_SEQ;
				end
			end
			PH_SEQ: begin
				seq_d   = data_byte;
				hcrc_d  = hcrc_step;
				fcrc_d  = fcrc_step;
				phase_d = PH_HCRC;
			end
			PH_HCRC: begin
				if (data_byte != hcrc_q) begin
					res_valid = 1'b1;
					res.kind  = KIND_REJECT;
					phase_d   = PH_HUNT;
					hcrc_d    = HCRC_INIT;
					fcrc_d    = FCRC_INIT;
				end else begin
					fcrc_d  = fcrc_step;
					count_d = '0;
					phase_d = PH_BODY;
				end
			end
			PH_BODY: begin
				res_valid    = 1'b1;
				res.value    = data_byte;
				res.position = count_q;
				fcrc_d       = fcrc_step;
				count_d      = count_inc;
				if ({6'b000000, count_inc} >= ({1'b0, len_q} + 17'd2)) begin
					phase_d = PH_TRL_LO;
				end
			end
			PH_TRL_LO: begin
				trl_d   = data_byte;
				phase_d = PH_TRL_HI;
			end
			PH_TRL_HI: begin
				res_valid    = 1'b1;
				res.kind     = ({data_byte, trl_q} == fcrc_q) ? KIND_GOOD : KIND_BAD;
				res.position = len_q[POS_W-1:0] + 11'd2;
				phase_d      = PH_HUNT;
				count_d      = '0;
				trl_d        = '0;
				hcrc_d       = HCRC_INIT;
				fcrc_d       = FCRC_INIT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q   <= '0;
			seq_q   <= '0;
			count_q <= '0;
			hcrc_q  <= HCRC_INIT;
			fcrc_q  <= FCRC_INIT;
			trl_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			seq_q   <= seq_d;
			count_q <= count_d;
			hcrc_q  <= hcrc_d;
			fcrc_q  <= fcrc_d;
			trl_q   <= trl_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= START_BYTE_RST;
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_START_BYTE:   start_q   <= cfg_wdata[BYTE_W-1:0];
				REG_MAX_DATA_LEN: max_len_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	cfp_out_skid u_out_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_res  (res),
		.space     (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign kind           = out_res.kind;
	assign value          = out_res.value;
	assign position       = out_res.position;
	assign payload_length = out_res.payload_length;
	assign sequence_res   = out_res.sequence_res;

endmodule

### src/cfp_port_checker.sv
`include "assert_macros.svh"

module cfp_port_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input cfp_pkg::kind_t              kind,
	input logic [cfp_pkg::BYTE_W-1:0]  value,
	input logic [cfp_pkg::POS_W-1:0]   position,
	input logic [cfp_pkg::LEN_W-1:0]   payload_length
);
	import cfp_pkg::*;

	`CFP_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(kind) && $stable(value) && $stable(position))
	`CFP_ASSERT_IMP(a_verdict_no_value, clk, arst_n, out_valid && kind != KIND_BYTE,
		value == 8'd0)
	`CFP_ASSERT_IMP(a_reject_pos, clk, arst_n, out_valid && kind == KIND_REJECT,
		position == 11'd0)
	`CFP_ASSERT_IMP(a_verdict_pos, clk, arst_n,
		out_valid && (kind == KIND_GOOD || kind == KIND_BAD),
		position == payload_length[POS_W-1:0] + 11'd2)
	`CFP_ASSERT_IMP(a_byte_in_frame, clk, arst_n, out_valid && kind == KIND_BYTE,
		({6'b000000, position} < ({1'b0, payload_length} + 17'd2)))

endmodule

bind crc_checked_frame_parser_core cfp_port_checker u_port_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.kind           (kind),
	.value          (value),
	.position       (position),
	.payload_length (payload_length)
);
